// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/sdspi_pkg.sv
// Types and constants of the SD SPI command engine.
`timescale 1ns / 1ps

package sdspi_pkg;

    // Item kinds on the input channel
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_RX    = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_READY_TIMEOUT     = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RESPONSE_ATTEMPTS = 1'd1;

    localparam logic [7:0] READY_TIMEOUT_RESET     = 8'd50;
    localparam logic [3:0] RESPONSE_ATTEMPTS_RESET = 4'd10;

    // Command indexes with special handling
    localparam logic [5:0] IDX_CMD0  = 6'd0;
    localparam logic [5:0] IDX_CMD8  = 6'd8;
    localparam logic [5:0] IDX_CMD12 = 6'd12;
    localparam logic [5:0] IDX_CMD55 = 6'd55;

    localparam logic [1:0] START_BITS = 2'b01;
    localparam logic [7:0] FILL_BYTE  = 8'hFF;
    localparam logic [7:0] CRC_CMD0   = 8'h95;
    localparam logic [7:0] CRC_CMD8   = 8'h87;
    localparam logic [7:0] CRC_OTHER  = 8'h01;
    localparam logic [7:0] RESP_OK_MAX = 8'h01;
    localparam logic [2:0] PKT_LAST   = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DESEL,
        PH_SEL,
        PH_READY,
        PH_FAIL,
        PH_PACKET,
        PH_STUFF,
        PH_RESP
    } phase_t;

endpackage

// File: rtl/sdspi_if.sv
// Valid/ready channel interfaces of the SD SPI command engine.
`timescale 1ns / 1ps

interface sdspi_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [5:0]  command_index;
    logic        app_command;
    logic [31:0] argument;
    logic [7:0]  rx_byte;

    modport source (output valid, cmd, command_index, app_command, argument, rx_byte,
                    input ready);
    modport sink   (input valid, cmd, command_index, app_command, argument, rx_byte,
                    output ready);
endinterface

interface sdspi_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       chip_select_level;
    logic       done_res;
    logic [7:0] response;

    modport source (output valid, tx_valid, tx_byte, chip_select_level, done_res, response,
                    input ready);
    modport sink   (input valid, tx_valid, tx_byte, chip_select_level, done_res, response,
                    output ready);
endinterface

// File: rtl/sd_spi_command_engine.sv
// SD SPI-mode command engine: sequencer for one command transaction.
// Result: registered, valid in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle; the sequencer decides the next byte
//   combinationally. Input stalls only while a result waits on a stalled output.
// Reset: rst_n (async, active low) returns to idle with chip select high and
//   loads the configuration defaults (50 ready ticks, 10 response attempts).
`timescale 1ns / 1ps

module sd_spi_command_engine (
    input  logic                                  clk,
    input  logic                                  rst_n,
    sdspi_in_if.sink                              in_ch,
    sdspi_out_if.source                           out_ch,
    input  logic                                  cfg_we,
    input  logic [sdspi_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sdspi_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Configuration registers
    logic [7:0] ready_timeout_reg;
    logic [3:0] response_attempts_reg;

    // Sequencer state
    sdspi_pkg::phase_t phase_reg, phase_next;
    logic [5:0]  index_reg, index_next;
    logic [31:0] arg_reg, arg_next;
    logic        app_reg, app_next;
    logic [2:0]  count_reg, count_next;
    logic [7:0]  ticks_reg, ticks_next;
    logic [3:0]  attempts_reg, attempts_next;
    logic        sel_reg, sel_next;

    // Result register
    logic       out_valid_reg;
    logic       tx_valid_reg, tx_valid_next;
    logic [7:0] tx_byte_reg, tx_byte_next;
    logic       done_reg, done_next;
    logic [7:0] response_reg, response_next;

    logic        accept;
    logic [5:0]  start_idx;     // index a start transaction begins with
    logic [5:0]  cur_idx;       // index of the command in flight
    logic [31:0] cur_arg;
    logic [3:0]  attempts_dec;
    logic [3:0]  attempts_load;
    logic        resp_retry;    // response still busy and attempts remain
    logic        resp_chain;    // CMD55 answered OK, go on with the real command

    // Command packet byte k: start+index, argument MSB first, then CRC
    function automatic logic [7:0] pkt_byte(input logic [2:0] k, input logic [5:0] idx,
                                            input logic [31:0] arg);
        logic [7:0] b;
        unique case (k)
            3'd0: b = {sdspi_pkg::START_BITS, idx};
            3'd1: b = arg[31:24];
            3'd2: b = arg[23:16];
            3'd3: b = arg[15:8];
            3'd4: b = arg[7:0];
            default:
            begin
                if (idx == sdspi_pkg::IDX_CMD0)
                    b = sdspi_pkg::CRC_CMD0;
                else if (idx == sdspi_pkg::IDX_CMD8)
                    b = sdspi_pkg::CRC_CMD8;
                else
                    b = sdspi_pkg::CRC_OTHER;
            end
        endcase
        return b;
    endfunction

    // A new transaction is taken whenever the result register is free or draining
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    assign start_idx     = in_ch.app_command ? sdspi_pkg::IDX_CMD55 : in_ch.command_index;
    assign cur_idx       = app_reg ? sdspi_pkg::IDX_CMD55 : index_reg;
    assign cur_arg       = app_reg ? 32'd0 : arg_reg;
    assign attempts_dec  = (attempts_reg != 4'd0) ? attempts_reg - 4'd1 : 4'd0;
    assign attempts_load = (response_attempts_reg != 4'd0) ? response_attempts_reg : 4'd1;
    assign resp_retry    = in_ch.rx_byte[7] && (attempts_dec != 4'd0);
    assign resp_chain    = app_reg && (in_ch.rx_byte <= sdspi_pkg::RESP_OK_MAX);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_timeout_reg     <= sdspi_pkg::READY_TIMEOUT_RESET;
            response_attempts_reg <= sdspi_pkg::RESPONSE_ATTEMPTS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sdspi_pkg::REG_READY_TIMEOUT:     ready_timeout_reg     <= cfg_data[7:0];
                sdspi_pkg::REG_RESPONSE_ATTEMPTS: response_attempts_reg <= cfg_data[3:0];
            endcase
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (in_ch.cmd == sdspi_pkg::CMD_START && phase_reg == sdspi_pkg::PH_IDLE)
            begin
                phase_next = (start_idx == sdspi_pkg::IDX_CMD12) ? sdspi_pkg::PH_PACKET
                                                                 : sdspi_pkg::PH_DESEL;
            end
            else if (in_ch.cmd == sdspi_pkg::CMD_RX)
            begin
                unique case (phase_reg)
                    sdspi_pkg::PH_IDLE:   phase_next = sdspi_pkg::PH_IDLE;
                    sdspi_pkg::PH_DESEL:  phase_next = sdspi_pkg::PH_SEL;
                    sdspi_pkg::PH_SEL:    phase_next = sdspi_pkg::PH_READY;
                    sdspi_pkg::PH_READY:
                    begin
                        if (in_ch.rx_byte == sdspi_pkg::FILL_BYTE)
                            phase_next = sdspi_pkg::PH_PACKET;
                        else if (ticks_reg == 8'd0)
                            phase_next = sdspi_pkg::PH_FAIL;
                    end
                    sdspi_pkg::PH_FAIL:   phase_next = sdspi_pkg::PH_IDLE;
                    sdspi_pkg::PH_PACKET:
                    begin
                        if (count_reg >= sdspi_pkg::PKT_LAST)
                            phase_next = (cur_idx == sdspi_pkg::IDX_CMD12) ?
                                         sdspi_pkg::PH_STUFF : sdspi_pkg::PH_RESP;
                    end
                    sdspi_pkg::PH_STUFF:  phase_next = sdspi_pkg::PH_RESP;
                    sdspi_pkg::PH_RESP:
                    begin
                        if (!resp_retry)
                        begin
                            if (resp_chain)
                                phase_next = (index_reg == sdspi_pkg::IDX_CMD12) ?
                                             sdspi_pkg::PH_PACKET : sdspi_pkg::PH_DESEL;
                            else
                                phase_next = sdspi_pkg::PH_IDLE;
                        end
                    end
                endcase
            end
        end
    end

    // Datapath and result
    always_comb
    begin
        index_next    = index_reg;
        arg_next      = arg_reg;
        app_next      = app_reg;
        count_next    = count_reg;
        ticks_next    = ticks_reg;
        attempts_next = attempts_reg;
        sel_next      = sel_reg;

        tx_valid_next = 1'b0;
        tx_byte_next  = sdspi_pkg::FILL_BYTE;
        done_next     = 1'b0;
        response_next = 8'd0;

        if (accept)
        begin
            unique case (in_ch.cmd)
                sdspi_pkg::CMD_TICK:
                begin
                    if (ticks_reg != 8'd0)
                        ticks_next = ticks_reg - 8'd1;
                end
                sdspi_pkg::CMD_START:
                begin
                    if (phase_reg == sdspi_pkg::PH_IDLE)
                    begin
                        index_next    = in_ch.command_index;
                        arg_next      = in_ch.argument;
                        app_next      = in_ch.app_command;
                        tx_valid_next = 1'b1;
                        if (start_idx == sdspi_pkg::IDX_CMD12)
                        begin
                            count_next   = 3'd0;
                            tx_byte_next = {sdspi_pkg::START_BITS, sdspi_pkg::IDX_CMD12};
                        end
                        else
                            sel_next = 1'b1;
                    end
                end
                sdspi_pkg::CMD_RX:
                begin
                    tx_valid_next = (phase_reg != sdspi_pkg::PH_IDLE);
                    unique case (phase_reg)
                        sdspi_pkg::PH_IDLE:  ;
                        sdspi_pkg::PH_DESEL: sel_next = 1'b0;
                        sdspi_pkg::PH_SEL:   ticks_next = ready_timeout_reg;
                        sdspi_pkg::PH_READY:
                        begin
                            if (in_ch.rx_byte == sdspi_pkg::FILL_BYTE)
                            begin
                                count_next   = 3'd0;
                                tx_byte_next = pkt_byte(3'd0, cur_idx, cur_arg);
                            end
                            else if (ticks_reg == 8'd0)
                                sel_next = 1'b1;
                        end
                        sdspi_pkg::PH_FAIL:
                        begin
                            // select timed out: finish with 0xFF
                            app_next      = 1'b0;
                            tx_valid_next = 1'b0;
                            done_next     = 1'b1;
                            response_next = sdspi_pkg::FILL_BYTE;
                        end
                        sdspi_pkg::PH_PACKET:
                        begin
                            if (count_reg < sdspi_pkg::PKT_LAST)
                            begin
                                count_next   = count_reg + 3'd1;
                                tx_byte_next = pkt_byte(count_reg + 3'd1, cur_idx, cur_arg);
                            end
                            else if (cur_idx != sdspi_pkg::IDX_CMD12)
                                attempts_next = attempts_load;
                        end
                        sdspi_pkg::PH_STUFF: attempts_next = attempts_load;
                        sdspi_pkg::PH_RESP:
                        begin
                            attempts_next = attempts_dec;
                            if (!resp_retry)
                            begin
                                app_next = 1'b0;
                                if (resp_chain)
                                begin
                                    // CMD55 accepted: start the application command
                                    if (index_reg == sdspi_pkg::IDX_CMD12)
                                    begin
                                        count_next   = 3'd0;
                                        tx_byte_next = {sdspi_pkg::START_BITS,
                                                        sdspi_pkg::IDX_CMD12};
                                    end
                                    else
                                        sel_next = 1'b1;
                                end
                                else
                                begin
                                    tx_valid_next = 1'b0;
                                    done_next     = 1'b1;
                                    response_next = in_ch.rx_byte;
                                end
                            end
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Sequencer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= sdspi_pkg::PH_IDLE;
            index_reg     <= 6'd0;
            arg_reg       <= 32'd0;
            app_reg       <= 1'b0;
            count_reg     <= 3'd0;
            ticks_reg     <= 8'd0;
            attempts_reg  <= 4'd0;
            sel_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            index_reg    <= index_next;
            arg_reg      <= arg_next;
            app_reg      <= app_next;
            count_reg    <= count_next;
            ticks_reg    <= ticks_next;
            attempts_reg <= attempts_next;
            sel_reg      <= sel_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded with each accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tx_valid_reg <= tx_valid_next;
            tx_byte_reg  <= tx_byte_next;
            done_reg     <= done_next;
            response_reg <= response_next;
        end
    end

    // chip select travels with the result it belongs to
    logic sel_out_reg;
    always_ff @(posedge clk)
    begin
        if (accept)
            sel_out_reg <= sel_next;
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.tx_valid          = tx_valid_reg;
    assign out_ch.tx_byte           = tx_byte_reg;
    assign out_ch.chip_select_level = sel_out_reg;
    assign out_ch.done_res          = done_reg;
    assign out_ch.response          = response_reg;

endmodule

// File: rtl/sdspi_checker.sv
// Port-level checker of the SD SPI command engine, bound into every engine instance.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sdspi_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] in_cmd,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_tx_valid,
    input logic [7:0] out_tx_byte,
    input logic       out_done,
    input logic [7:0] out_response
);

    logic in_accept;
    assign in_accept = rst_n && in_valid && in_ready;

    `ASSERT_NEXT(a_result_follows, clk, rst_n, in_accept, out_valid)
    `ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_tick_silent, clk, rst_n, in_accept && in_cmd == sdspi_pkg::CMD_TICK,
                 !out_tx_valid && !out_done)
    `ASSERT_IMPLIES(a_idle_fill, clk, rst_n, out_valid && !out_tx_valid,
                    out_tx_byte == sdspi_pkg::FILL_BYTE)
    `ASSERT_IMPLIES(a_resp_only_done, clk, rst_n, out_valid && !out_done,
                    out_response == 8'd0)

endmodule

bind sd_spi_command_engine sdspi_checker u_sdspi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_cmd       (in_ch.cmd),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_tx_valid (out_ch.tx_valid),
    .out_tx_byte  (out_ch.tx_byte),
    .out_done     (out_ch.done_res),
    .out_response (out_ch.response)
);

// File: sim/sd_spi_command_engine_tb.sv
// Self-checking testbench for the SD SPI-mode command engine.
`timescale 1ns / 1ps

module sd_spi_command_engine_tb;

    // Item kind that the engine must ignore without touching its state
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int unsigned ITEM_TARGET = 1550;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT = 800000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  index;
        logic        app;
        logic [31:0] arg;
        logic [7:0]  rx;
    } card_item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       cs_level;
        logic       done;
        logic [7:0] resp;
    } spi_reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                              cfg_we;
    logic [sdspi_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [sdspi_pkg::CFG_DATA_W-1:0]  cfg_data;

    sdspi_in_if  in_ch();
    sdspi_out_if out_ch();

    sd_spi_command_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Engine state mirrored by the predictor. Updated at the edge where
    // an input transaction is accepted, so the stimulus side can also
    // steer on it (e.g. keep answering until the command completes).
    // ------------------------------------------------------------------
    logic [7:0]        cfg_ready_ticks;
    logic [3:0]        cfg_tries;
    sdspi_pkg::phase_t eng_phase;
    logic [5:0]        lat_index;
    logic [31:0]       lat_arg;
    logic              in_app_prefix;
    logic [2:0]        pkt_pos;
    logic [7:0]        ticks_left;
    logic [3:0]        tries_left;
    logic              cs_level;

    spi_reply_t  due_replies[$];    // replies predicted but not yet seen
    spi_reply_t  want_reply;

    int unsigned errors;
    int unsigned item_count;        // every accepted input transaction
    int unsigned commands_done;
    int unsigned select_timeouts;
    int unsigned replies_checked;
    int unsigned cycle_count;

    // Sender burst/gap control
    bit          gaps_on;
    int unsigned burst_left;

    // Long receiver hold-offs: the test bumps holds_asked, the sink serves them
    int unsigned holds_asked;
    int unsigned holds_done;

    function automatic void reset_model();
        cfg_ready_ticks = sdspi_pkg::READY_TIMEOUT_RESET;
        cfg_tries       = sdspi_pkg::RESPONSE_ATTEMPTS_RESET;
        eng_phase       = sdspi_pkg::PH_IDLE;
        lat_index       = '0;
        lat_arg         = '0;
        in_app_prefix   = 1'b0;
        pkt_pos         = '0;
        ticks_left      = '0;
        tries_left      = '0;
        cs_level        = 1'b1;
    endfunction

    // While the CMD55 prefix runs, the frame carries index 55 and argument 0
    function automatic logic [5:0] live_index();
        return in_app_prefix ? sdspi_pkg::IDX_CMD55 : lat_index;
    endfunction

    function automatic logic [7:0] frame_byte(input logic [2:0] pos);
        logic [5:0]  idx;
        logic [31:0] a;
        idx = live_index();
        a   = in_app_prefix ? 32'd0 : lat_arg;
        case (pos)
            3'd0: return {sdspi_pkg::START_BITS, idx};
            3'd1: return a[31:24];
            3'd2: return a[23:16];
            3'd3: return a[15:8];
            3'd4: return a[7:0];
            default:
            begin
                if (idx == sdspi_pkg::IDX_CMD0)
                    return sdspi_pkg::CRC_CMD0;
                if (idx == sdspi_pkg::IDX_CMD8)
                    return sdspi_pkg::CRC_CMD8;
                return sdspi_pkg::CRC_OTHER;
            end
        endcase
    endfunction

    // CMD12 goes straight to the frame; everything else deselects first
    function automatic logic [7:0] open_command();
        if (live_index() != sdspi_pkg::IDX_CMD12)
        begin
            cs_level  = 1'b1;
            eng_phase = sdspi_pkg::PH_DESEL;
            return sdspi_pkg::FILL_BYTE;
        end
        eng_phase = sdspi_pkg::PH_PACKET;
        pkt_pos   = '0;
        return frame_byte(3'd0);
    endfunction

    // A zero attempt count still polls once
    function automatic logic [7:0] open_response();
        tries_left = (cfg_tries != 0) ? cfg_tries : 4'd1;
        eng_phase  = sdspi_pkg::PH_RESP;
        return sdspi_pkg::FILL_BYTE;
    endfunction

    // Expected reply for one accepted item; advances the mirrored state
    function automatic spi_reply_t spi_engine_step(input card_item_t it);
        spi_reply_t r;
        logic       tv;
        logic [7:0] tx;
        logic       dn;
        logic [7:0] rsp;
        tv = 1'b0;
        tx = sdspi_pkg::FILL_BYTE;
        dn = 1'b0;
        rsp = '0;
        if (it.kind == sdspi_pkg::CMD_TICK)
        begin
            if (ticks_left != 0)
                ticks_left = ticks_left - 8'd1;
        end
        else if (it.kind == sdspi_pkg::CMD_START)
        begin
            if (eng_phase == sdspi_pkg::PH_IDLE)
            begin
                lat_index     = it.index;
                in_app_prefix = it.app;
                lat_arg       = it.arg;
                tx            = open_command();
                tv            = 1'b1;
            end
        end
        else if (it.kind == sdspi_pkg::CMD_RX && eng_phase != sdspi_pkg::PH_IDLE)
        begin
            tv = 1'b1;
            case (eng_phase)
                sdspi_pkg::PH_DESEL:
                begin
                    cs_level  = 1'b0;
                    eng_phase = sdspi_pkg::PH_SEL;
                end
                sdspi_pkg::PH_SEL:
                begin
                    ticks_left = cfg_ready_ticks;
                    eng_phase  = sdspi_pkg::PH_READY;
                end
                sdspi_pkg::PH_READY:
                begin
                    if (it.rx == sdspi_pkg::FILL_BYTE)
                    begin
                        eng_phase = sdspi_pkg::PH_PACKET;
                        pkt_pos   = '0;
                        tx        = frame_byte(3'd0);
                    end
                    else if (ticks_left == 0)
                    begin
                        cs_level  = 1'b1;
                        eng_phase = sdspi_pkg::PH_FAIL;
                    end
                end
                sdspi_pkg::PH_FAIL:
                begin
                    // closing dummy byte after a select timeout
                    in_app_prefix = 1'b0;
                    eng_phase     = sdspi_pkg::PH_IDLE;
                    tv            = 1'b0;
                    dn            = 1'b1;
                    rsp           = sdspi_pkg::FILL_BYTE;
                    select_timeouts++;
                    commands_done++;
                end
                sdspi_pkg::PH_PACKET:
                begin
                    if (pkt_pos < sdspi_pkg::PKT_LAST)
                    begin
                        pkt_pos = pkt_pos + 3'd1;
                        tx      = frame_byte(pkt_pos);
                    end
                    else if (live_index() == sdspi_pkg::IDX_CMD12)
                        eng_phase = sdspi_pkg::PH_STUFF;
                    else
                        tx = open_response();
                end
                sdspi_pkg::PH_STUFF:
                    tx = open_response();
                default:
                begin
                    if (tries_left != 0)
                        tries_left = tries_left - 4'd1;
                    if (!(it.rx[7] && tries_left != 0))
                    begin
                        if (in_app_prefix && it.rx <= sdspi_pkg::RESP_OK_MAX)
                        begin
                            // CMD55 accepted: run the real command now
                            in_app_prefix = 1'b0;
                            tx = open_command();
                        end
                        else
                        begin
                            in_app_prefix = 1'b0;
                            eng_phase     = sdspi_pkg::PH_IDLE;
                            tv            = 1'b0;
                            dn            = 1'b1;
                            rsp           = it.rx;
                            commands_done++;
                        end
                    end
                end
            endcase
        end
        r.tx_valid = tv;
        r.tx_byte  = tx;
        r.cs_level = cs_level;
        r.done     = dn;
        r.resp     = rsp;
        return r;
    endfunction

    function automatic card_item_t mk_item(input logic [1:0] kind, input logic [5:0] index,
                                           input logic app, input logic [31:0] arg,
                                           input logic [7:0] rx);
        card_item_t it;
        it.kind  = kind;
        it.index = index;
        it.app   = app;
        it.arg   = arg;
        it.rx    = rx;
        return it;
    endfunction

    function automatic card_item_t random_fields(input logic [1:0] kind);
        return mk_item(kind, 6'($urandom), 1'($urandom), $urandom, 8'($urandom));
    endfunction

    // Noise while a command runs: tick, start while busy, or an unused kind
    function automatic card_item_t busy_noise();
        case ($urandom_range(0, 2))
            0:       return random_fields(sdspi_pkg::CMD_START);
            1:       return random_fields(sdspi_pkg::CMD_TICK);
            default: return random_fields(KIND_UNUSED);
        endcase
    endfunction

    // Noise while idle: stray received byte, tick, or an unused kind
    function automatic card_item_t idle_noise();
        case ($urandom_range(0, 2))
            0:       return random_fields(sdspi_pkg::CMD_RX);
            1:       return random_fields(sdspi_pkg::CMD_TICK);
            default: return random_fields(KIND_UNUSED);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input side: offer one item, hold it until the engine takes it.
    // Gaps between bursts drop valid.
    // ------------------------------------------------------------------
    task automatic send_item(input card_item_t it);
        int unsigned gap;
        if (gaps_on && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(1, 5);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (burst_left != 0)
            burst_left--;
        in_ch.valid         <= 1'b1;
        in_ch.cmd           <= it.kind;
        in_ch.command_index <= it.index;
        in_ch.app_command   <= it.app;
        in_ch.argument      <= it.arg;
        in_ch.rx_byte       <= it.rx;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        due_replies.push_back(spi_engine_step(it));
        item_count++;
    endtask

    // Stop offering and wait for every predicted reply to come out
    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_replies.size() != 0)
            @(posedge clk);
    endtask

    // Register writes happen only with nothing in flight
    task automatic write_reg(input logic [sdspi_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [7:0] data);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == sdspi_pkg::REG_READY_TIMEOUT)
            cfg_ready_ticks = data;
        else if (idx == sdspi_pkg::REG_RESPONSE_ATTEMPTS)
            cfg_tries = data[3:0];
    endtask

    // Play the card side of one command until the engine is idle again.
    // ready_busy_pct: chance a ready poll sees a busy card (100 = never ready).
    // resp_busy_pct: chance a response poll sees bit7 set.
    task automatic drive_command(input logic [5:0] idx, input logic app,
                                 input logic [31:0] arg,
                                 input int unsigned ready_busy_pct,
                                 input int unsigned resp_busy_pct,
                                 input logic [7:0] prefix_r1, input logic [7:0] final_r1,
                                 input int unsigned noise_pct);
        logic [7:0] rx;
        send_item(mk_item(sdspi_pkg::CMD_START, idx, app, arg, 8'($urandom)));
        while (eng_phase != sdspi_pkg::PH_IDLE)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_item(busy_noise());
            else if (eng_phase == sdspi_pkg::PH_READY && $urandom_range(0, 2) == 0)
                send_item(random_fields(sdspi_pkg::CMD_TICK));
            else
            begin
                case (eng_phase)
                    sdspi_pkg::PH_READY:
                        rx = ($urandom_range(0, 99) < ready_busy_pct)
                             ? 8'($urandom_range(0, 254)) : sdspi_pkg::FILL_BYTE;
                    sdspi_pkg::PH_RESP:
                        if ($urandom_range(0, 99) < resp_busy_pct)
                            rx = 8'h80 | 8'($urandom_range(0, 127));
                        else
                            rx = in_app_prefix ? prefix_r1 : final_r1;
                    default:
                        rx = 8'($urandom);   // don't-care bytes, any value
                endcase
                send_item(mk_item(sdspi_pkg::CMD_RX, 6'($urandom), 1'($urandom),
                                  $urandom, rx));
            end
        end
    endtask

    function automatic logic [7:0] random_r1();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return 8'h00;
        if (pick < 65)
            return 8'h01;
        if (pick < 90)
            return 8'($urandom_range(0, 127));
        return 8'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        // default 50 ticks / 10 attempts, card ready at once
        drive_command(sdspi_pkg::IDX_CMD0, 1'b0, 32'h0000_0000, 0, 0, 8'h00, 8'h01, 0);
    endtask

    task automatic test_frame_and_crc();
        drive_command(sdspi_pkg::IDX_CMD8, 1'b0, 32'h0000_01AA, 30, 30, 8'h00, 8'h01, 0);
        drive_command(6'd63, 1'b0, 32'hFFFF_FFFF, 0, 0, 8'h00, 8'h00, 0);
    endtask

    task automatic test_stop_command();
        // CMD12: no select sequence, one stuff byte before polling
        drive_command(sdspi_pkg::IDX_CMD12, 1'b0, 32'h0000_0000, 0, 50, 8'h00, 8'h00, 0);
    endtask

    task automatic test_app_prefix();
        drive_command(6'd41, 1'b1, 32'h4000_0000, 0, 0, 8'h01, 8'h00, 0);
        // CMD55 answer above 1 cuts the command short
        drive_command(6'd41, 1'b1, 32'h4000_0000, 0, 0, 8'h05, 8'h00, 0);
        drive_command(sdspi_pkg::IDX_CMD12, 1'b1, 32'h1234_5678, 0, 0, 8'h00, 8'h00, 0);
    endtask

    task automatic test_select_timeout();
        write_reg(sdspi_pkg::REG_READY_TIMEOUT, 8'd0);
        drive_command(sdspi_pkg::IDX_CMD0, 1'b0, 32'h0, 100, 0, 8'h00, 8'h01, 0);
        write_reg(sdspi_pkg::REG_READY_TIMEOUT, 8'd2);
        drive_command(6'd17, 1'b1, 32'h0, 100, 0, 8'h00, 8'h00, 0);
    endtask

    task automatic test_response_attempts();
        // zero attempts still polls once; upper data bits are dropped
        write_reg(sdspi_pkg::REG_RESPONSE_ATTEMPTS, 8'hF0);
        drive_command(6'd16, 1'b0, 32'h0000_0200, 0, 100, 8'h00, 8'h00, 0);
        write_reg(sdspi_pkg::REG_RESPONSE_ATTEMPTS, 8'h0F);
        drive_command(6'd16, 1'b0, 32'h0000_0200, 0, 100, 8'h00, 8'h00, 0);
    endtask

    task automatic test_ignored_items();
        send_item(random_fields(sdspi_pkg::CMD_RX));
        send_item(random_fields(sdspi_pkg::CMD_TICK));
        send_item(random_fields(KIND_UNUSED));
        // starts, ticks and unused kinds sprinkled into a running command
        drive_command(6'd9, 1'b0, $urandom, 20, 20, 8'h00, 8'h00, 40);
    endtask

    task automatic test_backpressure();
        // receiver holds off while the sender keeps offering back to back
        wait_drain();
        gaps_on = 1'b0;
        holds_asked++;
        drive_command(6'd24, 1'b0, $urandom, 0, 0, 8'h00, 8'h00, 0);
        // sender pauses until every reply has come
        wait_drain();
        gaps_on = 1'b1;
    endtask

    task automatic pick_config();
        int unsigned pick;
        logic [7:0]  ticks;
        logic [3:0]  tries;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            ticks = 8'd0;
        else if (pick < 15)
            ticks = 8'd255;
        else if (pick < 80)
            ticks = 8'($urandom_range(1, 6));
        else
            ticks = 8'($urandom_range(7, 60));
        pick = $urandom_range(0, 3);
        tries = (pick == 0) ? 4'd0 : (pick == 1) ? 4'd15 : 4'($urandom_range(1, 14));
        write_reg(sdspi_pkg::REG_READY_TIMEOUT, ticks);
        write_reg(sdspi_pkg::REG_RESPONSE_ATTEMPTS, {4'($urandom), tries});
    endtask

    task automatic test_random_traffic();
        int unsigned since_cfg;
        int unsigned pick;
        logic [5:0]  idx;
        logic [31:0] arg;
        int unsigned rdy_pct;
        int unsigned rsp_pct;
        logic [7:0]  pre_r1;
        since_cfg = 0;
        while (item_count < ITEM_TARGET)
        begin
            if (since_cfg >= 12)
            begin
                pick_config();
                gaps_on = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 3) == 0)
                    holds_asked++;
                since_cfg = 0;
            end
            pick = $urandom_range(0, 9);
            idx = (pick == 0) ? sdspi_pkg::IDX_CMD0 : (pick == 1) ? sdspi_pkg::IDX_CMD8 :
                  (pick == 2) ? sdspi_pkg::IDX_CMD12 :
                  (pick == 3) ? sdspi_pkg::IDX_CMD55 : 6'($urandom);
            pick = $urandom_range(0, 9);
            arg = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
            pick = $urandom_range(0, 99);
            rdy_pct = (pick < 50) ? 0 : (pick < 85) ? 40 : (pick < 95) ? 80 : 100;
            // a never-ready card under a long timeout would swamp the item budget
            if (cfg_ready_ticks > 8'd60 && rdy_pct == 100)
                rdy_pct = 80;
            pick = $urandom_range(0, 99);
            rsp_pct = (pick < 50) ? 0 : (pick < 80) ? 40 : 90;
            pre_r1 = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 1))
                                                 : 8'($urandom_range(0, 127));
            drive_command(idx, ($urandom_range(0, 9) < 3), arg, rdy_pct, rsp_pct,
                          pre_r1, random_r1(), 5);
            if ($urandom_range(0, 9) == 0)
                send_item(idle_noise());
            since_cfg++;
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: stall pattern redrawn at the end of each span, plus
    // long hold-offs on request.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned stall_pct;
        int unsigned span;
        int unsigned held;
        stall_pct = 0;
        span = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_asked)
            begin
                out_ch.ready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                holds_done++;
            end
            else
            begin
                if (span == 0)
                begin
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 25;
                        3:       stall_pct = 60;
                        default: stall_pct = 85;
                    endcase
                    span = 50;
                end
                span--;
                out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    // Every output transaction is matched against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (due_replies.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected reply, expected none, actual tx %0h resp %0h",
                         $time, out_ch.tx_byte, out_ch.response);
            end
            else
            begin
                want_reply = due_replies.pop_front();
                replies_checked++;
                check_field("tx_valid", 8'(want_reply.tx_valid), 8'(out_ch.tx_valid));
                check_field("tx_byte", want_reply.tx_byte, out_ch.tx_byte);
                check_field("chip_select_level", 8'(want_reply.cs_level),
                            8'(out_ch.chip_select_level));
                check_field("done_res", 8'(want_reply.done), 8'(out_ch.done_res));
                check_field("response", want_reply.resp, out_ch.response);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        errors          = 0;
        item_count      = 0;
        commands_done   = 0;
        select_timeouts = 0;
        replies_checked = 0;
        cycle_count     = 0;
        holds_asked     = 0;
        holds_done      = 0;
        gaps_on         = 1'b1;
        burst_left      = 0;
        reset_model();
        in_ch.valid         <= 1'b0;
        in_ch.cmd           <= sdspi_pkg::CMD_TICK;
        in_ch.command_index <= '0;
        in_ch.app_command   <= 1'b0;
        in_ch.argument      <= '0;
        in_ch.rx_byte       <= '0;
        cfg_we              <= 1'b0;
        cfg_index           <= '0;
        cfg_data            <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_frame_and_crc();
        test_stop_command();
        test_app_prefix();
        test_select_timeout();
        test_response_attempts();
        test_ignored_items();
        test_backpressure();
        test_random_traffic();

        wait_drain();
        repeat (8) @(posedge clk);
        if (due_replies.size() != 0)
        begin
            errors++;
            $display("%0t: %0d replies never arrived", $time, due_replies.size());
        end
        $display("summary: %0d items sent, %0d commands completed, %0d select timeouts",
                 item_count, commands_done, select_timeouts);
        $display("summary: %0d replies checked, %0d mismatches in %0d cycles",
                 replies_checked, errors, cycle_count);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
